/* rtl/core/crb_pkg.sv */
// ----------------------------------------------------------------------------
// crb_pkg
// shared types, constants and codes of the chunk reorder buffer
// ----------------------------------------------------------------------------
package crb_pkg;

  localparam int WINDOW_SLOTS  = 64;
  localparam int PAYLOAD_WIDTH = 32;

  localparam int NUM_W  = 32;
  localparam int DATA_W = 32;
  localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int PAY_W  = (PAYLOAD_WIDTH < DATA_W) ? PAYLOAD_WIDTH : DATA_W;

  localparam int CMD_DEPTH = 2;
  localparam int CMD_AW    = 1;
  localparam int CMD_CW    = 2;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-1:0] ADDR_REORDER_ENABLE = 3'd0;

  localparam logic [1:0] ST_HELD     = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_RELEASED = 2'd2;

  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [PAY_W-1:0]  pay_t;

  typedef enum logic {
    OP_REJECT,
    OP_STORE
  } op_e;

  typedef struct packed {
    logic [NUM_W-1:0]  chunk_number;
    logic [DATA_W-1:0] payload;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [NUM_W-1:0]  released_number;
    logic [DATA_W-1:0] released_payload;
    logic              last;
  } out_t;

  typedef struct packed {
    op_e              op;
    logic             starts_run;
    logic [NUM_W-1:0] number;
    slot_idx_t        slot;
    pay_t             payload;
  } cmd_t;

  typedef struct packed {
    logic [NUM_W-1:0] head_number;
    slot_idx_t        head_ptr;
    logic             run_done;
  } win_t;

endpackage

/* rtl/core/crb_front.sv */
// ----------------------------------------------------------------------------
// crb_front
// accepts chunks, checks the window and queues store or reject commands
// ----------------------------------------------------------------------------
module crb_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          enable_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  crb_pkg::in_t  in_data_i,
  input  crb_pkg::win_t win_i,
  input  logic          cmd_full_i,
  output logic          cmd_push_o,
  output crb_pkg::cmd_t cmd_o
);

  logic                        pending_q, pending_d;
  logic [crb_pkg::NUM_W-1:0]   offset;
  logic                        in_window;
  logic [crb_pkg::SLOT_W:0]    slot_sum;
  crb_pkg::slot_idx_t          slot;

  always_comb begin
    offset    = in_data_i.chunk_number - win_i.head_number;
    in_window = offset < crb_pkg::NUM_W'(crb_pkg::WINDOW_SLOTS);
    slot_sum  = {1'b0, win_i.head_ptr} + {1'b0, offset[crb_pkg::SLOT_W-1:0]};
    if (slot_sum >= (crb_pkg::SLOT_W+1)'(crb_pkg::WINDOW_SLOTS)) begin
      slot = crb_pkg::SLOT_W'(slot_sum - (crb_pkg::SLOT_W+1)'(crb_pkg::WINDOW_SLOTS));
    end else begin
      slot = slot_sum[crb_pkg::SLOT_W-1:0];
    end
  end

  // a store at the head starts a run that moves the head
  assign in_stall_o = cmd_full_i || pending_q;
  assign cmd_push_o = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o.op         = (enable_i && in_window) ? crb_pkg::OP_STORE : crb_pkg::OP_REJECT;
    cmd_o.starts_run = (offset == '0);
    cmd_o.number     = in_data_i.chunk_number;
    cmd_o.slot       = slot;
    cmd_o.payload    = in_data_i.payload[crb_pkg::PAY_W-1:0];
  end

  always_comb begin
    pending_d = pending_q;
    if (win_i.run_done) begin
      pending_d = 1'b0;
    end else if (cmd_push_o && cmd_o.op == crb_pkg::OP_STORE && cmd_o.starts_run) begin
      pending_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else begin
      pending_q <= pending_d;
    end
  end

endmodule

/* rtl/core/crb_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// crb_cmd_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module crb_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  crb_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output crb_pkg::cmd_t pop_data_o
);

  crb_pkg::cmd_t                entries_q [crb_pkg::CMD_DEPTH];
  logic [crb_pkg::CMD_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [crb_pkg::CMD_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [crb_pkg::CMD_CW-1:0]   count_q, count_d;
  logic                         do_push, do_pop;

  assign full_o     = (count_q == crb_pkg::CMD_CW'(crb_pkg::CMD_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entries_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == crb_pkg::CMD_AW'(crb_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == crb_pkg::CMD_AW'(crb_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/core/crb_back.sv */
// ----------------------------------------------------------------------------
// crb_back
// executes commands: owns the slot window, stores payloads, releases runs
// ----------------------------------------------------------------------------
module crb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  crb_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output crb_pkg::win_t win_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output crb_pkg::out_t out_data_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [crb_pkg::NUM_W-1:0]       head_number_q, head_number_d;
  crb_pkg::slot_idx_t              head_ptr_q, head_ptr_d;
  crb_pkg::slot_idx_t              ptr_inc;
  crb_pkg::slot_idx_t              cnt_q, cnt_d;
  logic [crb_pkg::WINDOW_SLOTS-1:0] occ_q, occ_d;
  logic                            out_valid_q, out_valid_d;
  crb_pkg::out_t                   out_q, out_d;
  logic                            out_free;
  logic                            run_last;
  logic                            run_done;

  crb_pkg::pay_t                   mem [crb_pkg::WINDOW_SLOTS];
  crb_pkg::pay_t                   rdata_q;
  logic                            mem_we;
  logic                            rd_en;
  crb_pkg::slot_idx_t              rd_addr;

  assign out_free = !out_valid_q || !out_stall_i;
  assign ptr_inc  = (head_ptr_q == crb_pkg::SLOT_W'(crb_pkg::WINDOW_SLOTS - 1)) ? '0
                                                                               : head_ptr_q + 1'b1;
  assign run_last = (cnt_q == crb_pkg::SLOT_W'(crb_pkg::WINDOW_SLOTS - 1)) || !occ_q[ptr_inc];

  always_comb begin
    state_d       = state_q;
    head_number_d = head_number_q;
    head_ptr_d    = head_ptr_q;
    cnt_d         = cnt_q;
    occ_d         = occ_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_d         = out_q;
    cmd_pop_o     = 1'b0;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = head_ptr_q;
    run_done      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i && out_free) begin
          cmd_pop_o = 1'b1;
          out_d.released_number  = cmd_i.number;
          out_d.released_payload = '0;
          out_d.last             = 1'b1;
          if (cmd_i.op == crb_pkg::OP_REJECT) begin
            out_valid_d  = 1'b1;
            out_d.status = crb_pkg::ST_REJECTED;
          end else begin
            mem_we              = 1'b1;
            occ_d[cmd_i.slot]   = 1'b1;
            if (cmd_i.starts_run) begin
              cnt_d   = '0;
              state_d = S_READ;
            end else begin
              out_valid_d  = 1'b1;
              out_d.status = crb_pkg::ST_HELD;
            end
          end
        end
      end
      S_READ: begin
        rd_en   = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_d.status           = crb_pkg::ST_RELEASED;
          out_d.released_number  = head_number_q;
          out_d.released_payload = crb_pkg::DATA_W'(rdata_q);
          out_d.last             = run_last;
          occ_d[head_ptr_q]      = 1'b0;
          head_number_d          = head_number_q + 1'b1;
          head_ptr_d             = ptr_inc;
          cnt_d                  = cnt_q + 1'b1;
          if (run_last) begin
            run_done = 1'b1;
            state_d  = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_inc;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      head_number_q <= '0;
      head_ptr_q    <= '0;
      cnt_q         <= '0;
      occ_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      head_number_q <= head_number_d;
      head_ptr_q    <= head_ptr_d;
      cnt_q         <= cnt_d;
      occ_q         <= occ_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // payload memory, registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cmd_i.slot] <= cmd_i.payload;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign win_o.head_number = head_number_q;
  assign win_o.head_ptr    = head_ptr_q;
  assign win_o.run_done    = run_done;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

  a_idle_head_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !occ_q[head_ptr_q])
    else $error("head slot occupied while idle");

  a_run_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ || state_q == S_EMIT) |-> occ_q[head_ptr_q])
    else $error("releasing an empty slot");

  a_released_follows_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == crb_pkg::ST_RELEASED
      |-> crb_pkg::NUM_W'(out_q.released_number + 1'b1) == head_number_q)
    else $error("released number out of step with head");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_done |=> state_q == S_IDLE && !occ_q[head_ptr_q])
    else $error("run end left the head slot occupied");

endmodule

/* rtl/core/chunk_reorder_buffer.sv */
// ----------------------------------------------------------------------------
// chunk_reorder_buffer
// sliding window reorder buffer: stores numbered chunks, releases in order
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   crb_pkg::in_t  (chunk_number, payload)
//  out      output     out_valid_o / out_stall_i crb_pkg::out_t (status, number, payload, last)
//  cfg      input      apb psel/penable/pready   reorder_enable at byte address 0
//
//  a rejected or held chunk: one transfer in, one result, one per cycle with queue room and no run pending
//  a chunk stored at the head: input stalls until its run of n chunks is out;
//  released chunks leave one per cycle while out_stall_i is low, set by the payload memory read port
//  reset clears the head, the occupied marks and the queue; no clearing pass
//  out_stall_i holds results in the output register; the command queue keeps input moving until it is full
module chunk_reorder_buffer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  crb_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output crb_pkg::out_t              out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [crb_pkg::CFG_AW-1:0] paddr,
  input  logic [crb_pkg::CFG_DW-1:0] pwdata,
  output logic [crb_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);

  logic          enable_q;
  logic          cfg_write;
  logic          cmd_full, cmd_empty, cmd_push, cmd_pop;
  crb_pkg::cmd_t cmd_in, cmd_out;
  crb_pkg::win_t win;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == crb_pkg::ADDR_REORDER_ENABLE);
  assign prdata    = (paddr == crb_pkg::ADDR_REORDER_ENABLE)
                     ? {{(crb_pkg::CFG_DW-1){1'b0}}, enable_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_write) begin
      enable_q <= pwdata[0];
    end
  end

  crb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .enable_i   (enable_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .win_i      (win),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  crb_cmd_fifo u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .push_data_i (cmd_in),
    .full_o      (cmd_full),
    .pop_i       (cmd_pop),
    .empty_o     (cmd_empty),
    .pop_data_o  (cmd_out)
  );

  crb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .win_o       (win),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
